// ===== sv/srd_pkg.sv =====
// Shared types, codes and the CRC step for the sector RLE decoder.
// No dependencies; used by the front, back and top level.
package srd_pkg;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_GOOD     = 3'd1;
  localparam logic [2:0] ST_OVER     = 3'd2;
  localparam logic [2:0] ST_MISM     = 3'd3;
  localparam logic [2:0] ST_CRC      = 3'd4;
  localparam logic [2:0] ST_READ     = 3'd5;

  localparam logic [7:0]  ENC_LITERAL = 8'd0;
  localparam logic [7:0]  ENC_PAIR    = 8'd1;
  localparam logic [7:0]  ENC_BLOCKS  = 8'd2;
  localparam logic [7:0]  BLK_LITERAL = 8'd0;
  localparam logic [7:0]  BLK_PAIR    = 8'd1;
  localparam logic [15:0] CRC_POLY    = 16'hA097;
  localparam logic [15:0] BASE_SIZE   = 16'd128;

  localparam int ERR_OVER = 0;
  localparam int ERR_MISM = 1;

  typedef enum logic [1:0] {
    KIND_FEED = 2'd0,
    KIND_OPEN = 2'd1,
    KIND_READ = 2'd2
  } srd_kind_t;

  typedef struct packed {
    srd_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  size_code;
    logic [7:0]  exp_crc;
    logic [12:0] read_index;
  } srd_cmd_t;

  typedef enum logic [12:0] {
    PH_IDLE      = 13'b0000000000001,
    PH_T0_DATA   = 13'b0000000000010,
    PH_T1_LO     = 13'b0000000000100,
    PH_T1_HI     = 13'b0000000001000,
    PH_T1_D1     = 13'b0000000010000,
    PH_T1_D2     = 13'b0000000100000,
    PH_SKIP      = 13'b0000001000000,
    PH_T2_BLK    = 13'b0000010000000,
    PH_T2_LITLEN = 13'b0000100000000,
    PH_T2_LIT    = 13'b0001000000000,
    PH_T2_PLEN   = 13'b0010000000000,
    PH_T2_PD1    = 13'b0100000000000,
    PH_T2_PD2    = 13'b1000000000000
  } srd_phase_t;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_FILL    = 7'b0000010,
    S_FIN     = 7'b0000100,
    S_CRC_RD  = 7'b0001000,
    S_CRC_UPD = 7'b0010000,
    S_READ    = 7'b0100000,
    S_RES     = 7'b1000000
  } srd_state_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== sv/srd_if.sv =====
// Channel interfaces for the sector RLE decoder: request and result words.
// Standalone; fields follow the block's item layout.
interface srd_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  in_byte;
  logic        first_byte;
  logic        last_byte;
  logic [2:0]  size_code;
  logic [7:0]  expected_crc;
  logic [12:0] read_index;
  modport source (output valid, req_type, in_byte, first_byte, last_byte, size_code,
                  expected_crc, read_index, input ready);
  modport sink (input valid, req_type, in_byte, first_byte, last_byte, size_code,
                expected_crc, read_index, output ready);
endinterface

interface srd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [2:0]  status;
  logic [13:0] sector_length;
  modport source (output valid, read_data, status, sector_length, input ready);
  modport sink (input valid, read_data, status, sector_length, output ready);
endinterface

// ===== sv/srd_front.sv =====
// Front end: accepts request words, classifies them and queues two deep.
// Depends on srd_pkg and srd_in_if.
module srd_front (
  input  logic              clk,
  input  logic              rst_n,
  srd_in_if.sink            in_ch,
  output srd_pkg::srd_cmd_t cmd,
  output logic              cmd_valid,
  input  logic              cmd_pop
);
  import srd_pkg::*;

  srd_cmd_t   ent_r [2];
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  srd_cmd_t   new_cmd;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = ent_r[rd_ptr_r];

  always_comb begin
    new_cmd.kind       = in_ch.req_type ? KIND_READ : (in_ch.first_byte ? KIND_OPEN : KIND_FEED);
    new_cmd.data       = in_ch.in_byte;
    new_cmd.last       = in_ch.last_byte;
    new_cmd.size_code  = in_ch.size_code;
    new_cmd.exp_crc    = in_ch.expected_crc;
    new_cmd.read_index = in_ch.read_index;
    rd_ptr_nxt = rd_ptr_r ^ (cmd_pop && cmd_valid);
    wr_ptr_nxt = wr_ptr_r ^ push;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, cmd_pop && cmd_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= new_cmd;
  end

endmodule

// ===== sv/srd_back.sv =====
// Back end: decode sequencer, sector memory, CRC walk and result register.
// Depends on srd_pkg and srd_out_if.
module srd_back #(
  parameter int MAX_SIZE_CODE = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  srd_pkg::srd_cmd_t cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  srd_out_if.source         out_ch
);
  import srd_pkg::*;

  localparam int AW    = 7 + MAX_SIZE_CODE;
  localparam int WPW   = AW + 1;
  localparam int DEPTH = 1 << AW;
  localparam logic [2:0] MAX_CODE = 3'(MAX_SIZE_CODE);

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q_r;
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [7:0]     wdata;

  srd_state_t      state_r, state_nxt;
  srd_phase_t      phase_r, phase_nxt;
  logic [7:0]      etype_r, etype_nxt;
  logic [15:0]     pend_r, pend_nxt;
  logic [15:0]     pair_r, pair_nxt;
  logic [2:0]      rsc_r, rsc_nxt;
  logic [7:0]      exp_r, exp_nxt;
  logic [1:0]      err_r, err_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [WPW-1:0]  wp_r, wp_nxt;
  logic [WPW-1:0]  ci_r, ci_nxt;
  logic            half_r, half_nxt;
  logic            last_r, last_nxt;
  logic            hit_r, hit_nxt;
  logic [7:0]      res_data_r, res_data_nxt;
  logic [2:0]      res_status_r, res_status_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_data_r, out_data_nxt;
  logic [2:0]      out_status_r, out_status_nxt;
  logic [13:0]     out_len_r, out_len_nxt;

  logic [WPW-1:0]  size;
  logic [15:0]     size_len;
  logic            wp_lt;
  logic [WPW-1:0]  ci_inc;
  logic [13:0]     idx_ext;
  logic [16:0]     dbl;
  logic            mism;
  logic [7:0]      crc_in;

  assign size     = {{(WPW-1){1'b0}}, 1'b1} << (4'(rsc_r) + 4'd7);
  assign size_len = BASE_SIZE << rsc_r;
  assign wp_lt    = wp_r < size;
  assign ci_inc   = ci_r + 1'b1;
  assign idx_ext  = {1'b0, cmd.read_index};
  assign dbl      = {cmd.data, pend_r[7:0], 1'b0};
  assign crc_in   = (ci_r < wp_r) ? mem_q_r : 8'd0;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_data     = out_data_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.sector_length = out_len_r;

  always_comb begin
    state_nxt = state_r;   phase_nxt = phase_r;   etype_nxt = etype_r;
    pend_nxt = pend_r;     pair_nxt = pair_r;     rsc_nxt = rsc_r;
    exp_nxt = exp_r;       err_nxt = err_r;       crc_nxt = crc_r;
    wp_nxt = wp_r;         ci_nxt = ci_r;         half_nxt = half_r;
    last_nxt = last_r;     hit_nxt = hit_r;
    res_data_nxt = res_data_r;  res_status_nxt = res_status_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt = out_data_r;  out_status_nxt = out_status_r;  out_len_nxt = out_len_r;
    cmd_pop = 1'b0;
    we = 1'b0;  waddr = wp_r[AW-1:0];  wdata = 8'd0;
    raddr = ci_r[AW-1:0];
    mism = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          last_nxt       = cmd.last;
          res_data_nxt   = 8'd0;
          res_status_nxt = ST_ACCEPTED;
          state_nxt      = S_RES;
          case (cmd.kind)
            KIND_READ: begin
              raddr     = idx_ext[AW-1:0];
              hit_nxt   = 16'(cmd.read_index) < 16'(wp_r);
              state_nxt = S_READ;
            end
            KIND_OPEN: begin
              rsc_nxt   = (cmd.size_code > MAX_CODE) ? MAX_CODE : cmd.size_code;
              exp_nxt   = cmd.exp_crc;
              etype_nxt = cmd.data;
              wp_nxt    = '0;
              pend_nxt  = 16'd0;
              pair_nxt  = 16'd0;
              err_nxt   = 2'b00;
              if (cmd.data == ENC_LITERAL) phase_nxt = PH_T0_DATA;
              else if (cmd.data == ENC_PAIR) phase_nxt = PH_T1_LO;
              else if (cmd.data == ENC_BLOCKS) phase_nxt = PH_T2_BLK;
              else phase_nxt = PH_SKIP;
              if (cmd.last) state_nxt = S_FIN;
            end
            default: begin
              if (phase_r != PH_IDLE) begin
                if (cmd.last) state_nxt = S_FIN;
                case (phase_r)
                  PH_T0_DATA: begin
                    if (wp_lt) begin
                      we = 1'b1;  wdata = cmd.data;  wp_nxt = wp_r + 1'b1;
                    end else err_nxt[ERR_OVER] = 1'b1;
                  end
                  PH_T1_LO: begin
                    pend_nxt  = {8'd0, cmd.data};
                    phase_nxt = PH_T1_HI;
                  end
                  PH_T1_HI: begin
                    pend_nxt = {cmd.data, pend_r[7:0]};
                    if (dbl > 17'(size)) begin
                      err_nxt[ERR_OVER] = 1'b1;
                      phase_nxt = PH_SKIP;
                    end else phase_nxt = PH_T1_D1;
                  end
                  PH_T1_D1: begin
                    pair_nxt  = {8'd0, cmd.data};
                    phase_nxt = PH_T1_D2;
                  end
                  PH_T1_D2: begin
                    pair_nxt  = {cmd.data, pair_r[7:0]};
                    phase_nxt = PH_SKIP;
                    half_nxt  = 1'b0;
                    state_nxt = S_FILL;
                  end
                  PH_T2_BLK: begin
                    if (!wp_lt) begin
                      err_nxt[ERR_MISM] = 1'b1;
                      phase_nxt = PH_SKIP;
                    end else if (cmd.data == BLK_LITERAL) phase_nxt = PH_T2_LITLEN;
                    else if (cmd.data == BLK_PAIR) phase_nxt = PH_T2_PLEN;
                  end
                  PH_T2_LITLEN: begin
                    pend_nxt  = {8'd0, cmd.data};
                    phase_nxt = (cmd.data != 8'd0) ? PH_T2_LIT : PH_T2_BLK;
                  end
                  PH_T2_LIT: begin
                    if (!wp_lt) begin
                      err_nxt[ERR_MISM] = 1'b1;
                      phase_nxt = PH_SKIP;
                    end else begin
                      we = 1'b1;  wdata = cmd.data;  wp_nxt = wp_r + 1'b1;
                      pend_nxt = pend_r - 16'd1;
                      if (pend_r == 16'd1) phase_nxt = PH_T2_BLK;
                    end
                  end
                  PH_T2_PLEN: begin
                    pend_nxt  = {8'd0, cmd.data};
                    phase_nxt = PH_T2_PD1;
                  end
                  PH_T2_PD1: begin
                    pair_nxt  = {8'd0, cmd.data};
                    phase_nxt = PH_T2_PD2;
                  end
                  PH_T2_PD2: begin
                    pair_nxt  = {cmd.data, pair_r[7:0]};
                    phase_nxt = PH_T2_BLK;
                    half_nxt  = 1'b0;
                    state_nxt = S_FILL;
                  end
                  default: ;
                endcase
              end
            end
          endcase
        end
      end
      S_FILL: begin
        if (!half_r) begin
          if (pend_r == 16'd0 || !wp_lt) begin
            state_nxt = last_r ? S_FIN : S_RES;
          end else begin
            we = 1'b1;  wdata = pair_r[7:0];  wp_nxt = wp_r + 1'b1;
            half_nxt = 1'b1;
          end
        end else begin
          if (wp_lt) begin
            we = 1'b1;  wdata = pair_r[15:8];  wp_nxt = wp_r + 1'b1;
          end else err_nxt[ERR_OVER] = 1'b1;
          half_nxt = 1'b0;
          pend_nxt = pend_r - 16'd1;
        end
      end
      S_FIN: begin
        mism = (phase_r == PH_T1_LO) || (phase_r == PH_T1_HI) || (phase_r == PH_T1_D1) ||
               (phase_r == PH_T1_D2) || (phase_r == PH_T2_LITLEN) ||
               (phase_r == PH_T2_PLEN) || (phase_r == PH_T2_PD1) ||
               (phase_r == PH_T2_PD2) || ((etype_r == ENC_BLOCKS) && (wp_r != size));
        phase_nxt = PH_IDLE;
        err_nxt[ERR_MISM] = err_r[ERR_MISM] | mism;
        if (err_r[ERR_OVER]) begin
          res_status_nxt = ST_OVER;
          state_nxt = S_RES;
        end else if (err_r[ERR_MISM] || mism) begin
          res_status_nxt = ST_MISM;
          state_nxt = S_RES;
        end else begin
          ci_nxt  = '0;
          crc_nxt = 16'd0;
          state_nxt = S_CRC_RD;
        end
      end
      S_CRC_RD: begin
        state_nxt = S_CRC_UPD;
      end
      S_CRC_UPD: begin
        crc_nxt = crc16_byte(crc_r, crc_in);
        ci_nxt  = ci_inc;
        if (ci_inc == size) begin
          res_status_nxt = (crc_nxt[7:0] != exp_r) ? ST_CRC : ST_GOOD;
          state_nxt = S_RES;
        end else state_nxt = S_CRC_RD;
      end
      S_READ: begin
        res_data_nxt   = hit_r ? mem_q_r : 8'd0;
        res_status_nxt = ST_READ;
        state_nxt      = S_RES;
      end
      S_RES: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
          out_len_nxt    = size_len[13:0];
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    mem_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      etype_r     <= 8'd0;
      rsc_r       <= 3'd0;
      exp_r       <= 8'd0;
      err_r       <= 2'b00;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      etype_r     <= etype_nxt;
      rsc_r       <= rsc_nxt;
      exp_r       <= exp_nxt;
      err_r       <= err_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r       <= pend_nxt;
    pair_r       <= pair_nxt;
    crc_r        <= crc_nxt;
    ci_r         <= ci_nxt;
    half_r       <= half_nxt;
    last_r       <= last_nxt;
    hit_r        <= hit_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
  end

endmodule

// ===== sv/sector_rle_decoder_crc_top.sv =====
// Top level of the sector RLE decoder with CRC-16 check.
// Depends on srd_pkg, srd_if, srd_front and srd_back.
//
//   channel  | dir | handshake    | word
//   in_ch    | in  | valid/ready  | request: feed a record byte or read a sector byte
//   out_ch   | out | valid/ready  | result: read data, status, sector length
//
// A plain feed word passes the result state and a read word also the memory read state;
// pair expansion writes each pair byte by byte through the single sector memory write port.
// The closing byte of an error-free sector starts a CRC walk over every sector byte in memory.
// Bytes past the fill count read as zero, so no memory clearing runs after reset.
// A two-word queue and the output register let input and output stall independently.
module sector_rle_decoder_crc_top #(
  parameter int MAX_SIZE_CODE = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  srd_in_if.sink    in_ch,
  srd_out_if.source out_ch
);
  import srd_pkg::*;

  srd_cmd_t cmd;
  logic     cmd_valid;
  logic     cmd_pop;

  srd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  srd_back #(.MAX_SIZE_CODE(MAX_SIZE_CODE)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status <= ST_READ))
    else $error("result status out of range");

  a_length_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((MAX_SIZE_CODE == 7) ||
                      ($onehot(out_ch.sector_length) && out_ch.sector_length[6:0] == 7'd0)))
    else $error("sector length not a legal size");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("queue popped while empty");

endmodule
